>>> rtl/core/touch_contact_id_tracker_assert.svh
// ----------------------------------------------------------------------------
// Touch contact id tracker assertion macros
// Clocked property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TOUCH_CONTACT_ID_TRACKER_ASSERT_SVH
`define TOUCH_CONTACT_ID_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TCIT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcit assertion failed");

// next-cycle implication
`define TCIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcit assertion failed");

`endif

>>> rtl/core/tcit_pkg.sv
// ----------------------------------------------------------------------------
// Touch contact id tracker package
// Sizes, request and action codes, and the table control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tcit_pkg;

  localparam int MaxContacts = 8;
  localparam int IdxW        = $clog2(MaxContacts);
  localparam int CntW        = $clog2(MaxContacts + 1);

  typedef enum logic [1:0] {
    REQ_DOWN = 2'd0,
    REQ_MOVE = 2'd1,
    REQ_UP   = 2'd2,
    REQ_TICK = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ACT_DOWN = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_UP   = 2'd2
  } act_e;

  typedef struct packed {
    logic            add;
    logic            upd;
    logic            rm;
    logic            clr;
    logic [IdxW-1:0] idx;
  } tbl_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            hit;
    logic [IdxW-1:0] ptr;
    logic [IdxW-1:0] free_ptr;
    logic [15:0]     pos_x;
    logic [15:0]     pos_y;
  } tbl_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/tcit_table.sv
// ----------------------------------------------------------------------------
// Contact table
// Compact contact list with one finger comparator at the read index,
// lowest free pointer search, append, position update and shift-down removal.
// ----------------------------------------------------------------------------
`default_nettype none

module tcit_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcit_pkg::tbl_cmd_t  cmd_i,
  input  logic [15:0]         finger_i,
  input  logic [15:0]         pos_x_i,
  input  logic [15:0]         pos_y_i,
  output tcit_pkg::tbl_stat_t stat_o
);

  logic [15:0]               finger_q [tcit_pkg::MaxContacts];
  logic [tcit_pkg::IdxW-1:0] ptr_q    [tcit_pkg::MaxContacts];
  logic [15:0]               pos_x_q  [tcit_pkg::MaxContacts];
  logic [15:0]               pos_y_q  [tcit_pkg::MaxContacts];
  logic [tcit_pkg::CntW-1:0] count_q, count_d;

  logic [tcit_pkg::MaxContacts-1:0] used;
  logic [tcit_pkg::IdxW-1:0]        free_ptr;
  logic [tcit_pkg::IdxW-1:0]        wr_idx;

  assign wr_idx = count_q[tcit_pkg::IdxW-1:0];

  always_comb begin
    used = '0;
    for (int i = 0; i < tcit_pkg::MaxContacts; i++) begin
      if (tcit_pkg::CntW'(i) < count_q) begin
        used[ptr_q[i]] = 1'b1;
      end
    end
    free_ptr = '0;
    for (int p = tcit_pkg::MaxContacts - 1; p >= 0; p--) begin
      if (!used[p]) begin
        free_ptr = tcit_pkg::IdxW'(p);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clr) begin
      count_d = '0;
    end else if (cmd_i.add) begin
      count_d = count_q + tcit_pkg::CntW'(1);
    end else if (cmd_i.rm) begin
      count_d = count_q - tcit_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rm) begin
      for (int i = 0; i < tcit_pkg::MaxContacts - 1; i++) begin
        if (tcit_pkg::IdxW'(i) >= cmd_i.idx) begin
          finger_q[i] <= finger_q[i+1];
          ptr_q[i]    <= ptr_q[i+1];
          pos_x_q[i]  <= pos_x_q[i+1];
          pos_y_q[i]  <= pos_y_q[i+1];
        end
      end
    end
    if (cmd_i.add) begin
      finger_q[wr_idx] <= finger_i;
      ptr_q[wr_idx]    <= free_ptr;
      pos_x_q[wr_idx]  <= pos_x_i;
      pos_y_q[wr_idx]  <= pos_y_i;
    end
    if (cmd_i.upd) begin
      pos_x_q[cmd_i.idx] <= pos_x_i;
      pos_y_q[cmd_i.idx] <= pos_y_i;
    end
  end

  assign stat_o.count    = count_q;
  assign stat_o.hit      = (finger_q[cmd_i.idx] == finger_i);
  assign stat_o.ptr      = ptr_q[cmd_i.idx];
  assign stat_o.free_ptr = free_ptr;
  assign stat_o.pos_x    = pos_x_q[cmd_i.idx];
  assign stat_o.pos_y    = pos_y_q[cmd_i.idx];

endmodule

`default_nettype wire

>>> rtl/core/touch_contact_id_tracker.sv
// ----------------------------------------------------------------------------
// Touch contact id tracker
// Maps panel finger ids to the lowest free pointer id and emits pointer
// down, move and up results, with idle release of all contacts.
// ----------------------------------------------------------------------------
// Usage: the block holds up to 8 contacts and works on one request at a time;
// in_stall_o stays high until the request is fully handled. A touch request
// scans the table one entry per cycle through a single finger comparator: a
// new finger scans every entry before its down result and a known finger
// stops at its table index; extra results may come too (an up for a re-pressed
// finger, or one up per entry when a new finger lands on a full table). A tick
// adds to the idle time, or releases the table when the idle timeout expires.
// Results leave one per cycle through a single output register; a stalled
// output holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_contact_id_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        finger_id_i,
  input  logic [15:0]        touch_x_i,
  input  logic [15:0]        touch_y_i,
  input  logic [15:0]        tick_amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         action_o,
  output logic [2:0]         pointer_id_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic               last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UP_OLD,
    ST_HIT,
    ST_RELEASE,
    ST_ADD
  } state_e;

  state_e                    state_q, state_d;
  logic [1:0]                req_q, req_d;
  logic [15:0]               finger_q, finger_d;
  logic [15:0]               px_q, px_d;
  logic [15:0]               py_q, py_d;
  logic [tcit_pkg::CntW-1:0] idx_q, idx_d;
  logic [16:0]               idle_q, idle_d;
  logic [15:0]               timeout_q, timeout_d;
  logic                      rel_tick_q, rel_tick_d;

  logic                      out_valid_q, out_valid_d;
  logic [1:0]                action_q, action_d;
  logic [2:0]                pid_q, pid_d;
  logic [15:0]               pos_x_q, pos_x_d;
  logic [15:0]               pos_y_q, pos_y_d;
  logic                      last_q, last_d;

  tcit_pkg::tbl_cmd_t        cmd;
  tcit_pkg::tbl_stat_t       stat;

  logic                      out_free;
  logic                      emit;
  logic                      last_entry;
  logic [16:0]               idle_sum;
  logic [15:0]               in_px;
  logic [15:0]               in_py;

  tcit_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .finger_i (finger_q),
    .pos_x_i  (px_q),
    .pos_y_i  (py_q),
    .stat_o   (stat)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_entry = ((idx_q + tcit_pkg::CntW'(1)) == stat.count);
  assign idle_sum   = idle_q + {1'b0, tick_amount_i};
  assign in_px      = {~touch_x_i[15], touch_x_i[14:0]};
  assign in_py      = (touch_y_i == 16'd0) ? 16'h7fff : (16'h8000 - touch_y_i);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    finger_d   = finger_q;
    px_d       = px_q;
    py_d       = py_q;
    idx_d      = idx_q;
    idle_d     = idle_q;
    timeout_d  = cfg_we_i ? cfg_wdata_i : timeout_q;
    rel_tick_d = rel_tick_q;
    cmd        = '0;
    cmd.idx    = idx_q[tcit_pkg::IdxW-1:0];
    emit       = 1'b0;
    action_d   = action_q;
    pid_d      = pid_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    last_d     = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d    = req_type_i;
          finger_d = finger_id_i;
          px_d     = in_px;
          py_d     = in_py;
          idx_d    = '0;
          if (req_type_i == tcit_pkg::REQ_TICK) begin
            if (idle_q < {1'b0, timeout_q}) begin
              idle_d = idle_sum;
              if (idle_sum >= {1'b0, timeout_q} && stat.count != '0) begin
                rel_tick_d = 1'b1;
                state_d    = ST_RELEASE;
              end
            end
          end else begin
            idle_d  = '0;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (idx_q == stat.count) begin
          idx_d = '0;
          if (req_q == tcit_pkg::REQ_UP) begin
            state_d = ST_IDLE;
          end else if (stat.count == tcit_pkg::CntW'(tcit_pkg::MaxContacts)) begin
            rel_tick_d = 1'b0;
            state_d    = ST_RELEASE;
          end else begin
            state_d = ST_ADD;
          end
        end else if (stat.hit) begin
          state_d = (req_q == tcit_pkg::REQ_DOWN) ? ST_UP_OLD : ST_HIT;
        end else begin
          idx_d = idx_q + tcit_pkg::CntW'(1);
        end
      end
      ST_UP_OLD: begin
        if (out_free) begin
          emit     = 1'b1;
          action_d = tcit_pkg::ACT_UP;
          pid_d    = 3'(stat.ptr);
          pos_x_d  = stat.pos_x;
          pos_y_d  = stat.pos_y;
          last_d   = 1'b0;
          cmd.rm   = 1'b1;
          state_d  = ST_ADD;
        end
      end
      ST_HIT: begin
        if (out_free) begin
          emit     = 1'b1;
          pid_d    = 3'(stat.ptr);
          pos_x_d  = px_q;
          pos_y_d  = py_q;
          last_d   = 1'b1;
          if (req_q == tcit_pkg::REQ_UP) begin
            action_d = tcit_pkg::ACT_UP;
            cmd.rm   = 1'b1;
          end else begin
            action_d = tcit_pkg::ACT_MOVE;
            cmd.upd  = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_RELEASE: begin
        if (out_free) begin
          emit     = 1'b1;
          action_d = tcit_pkg::ACT_UP;
          pid_d    = 3'(stat.ptr);
          pos_x_d  = stat.pos_x;
          pos_y_d  = stat.pos_y;
          last_d   = rel_tick_q && last_entry;
          if (last_entry) begin
            cmd.clr = 1'b1;
            idx_d   = '0;
            state_d = rel_tick_q ? ST_IDLE : ST_ADD;
          end else begin
            idx_d = idx_q + tcit_pkg::CntW'(1);
          end
        end
      end
      ST_ADD: begin
        if (out_free) begin
          emit     = 1'b1;
          action_d = tcit_pkg::ACT_DOWN;
          pid_d    = 3'(stat.free_ptr);
          pos_x_d  = px_q;
          pos_y_d  = py_q;
          last_d   = 1'b1;
          cmd.add  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      idle_q      <= '0;
      timeout_q   <= 16'd1000;
      rel_tick_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      idle_q      <= idle_d;
      timeout_q   <= timeout_d;
      rel_tick_q  <= rel_tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    finger_q <= finger_d;
    px_q     <= px_d;
    py_q     <= py_d;
    action_q <= action_d;
    pid_q    <= pid_d;
    pos_x_q  <= pos_x_d;
    pos_y_q  <= pos_y_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = action_q;
  assign pointer_id_o = pid_q;
  assign pos_x_o      = pos_x_q;
  assign pos_y_o      = pos_y_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

>>> rtl/core/tcit_checker.sv
// ----------------------------------------------------------------------------
// Touch contact id tracker checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_contact_id_tracker_assert.svh"

module tcit_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [1:0]  action_i,
  input logic [2:0]  pointer_id_i,
  input logic [15:0] pos_x_i,
  input logic [15:0] pos_y_i,
  input logic        last_i
);

  `TCIT_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(action_i) && $stable(pointer_id_i) && $stable(pos_x_i) && $stable(pos_y_i) && $stable(last_i))
  `TCIT_ASSERT_NOW(a_move_last, out_valid_i && action_i == tcit_pkg::ACT_MOVE, last_i)
  `TCIT_ASSERT_NOW(a_down_last, out_valid_i && action_i == tcit_pkg::ACT_DOWN, last_i)
  `TCIT_ASSERT_NOW(a_y_sat, out_valid_i, pos_y_i != 16'h8000)

endmodule

bind touch_contact_id_tracker tcit_checker u_tcit_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .action_i     (action_o),
  .pointer_id_i (pointer_id_o),
  .pos_x_i      (pos_x_o),
  .pos_y_i      (pos_y_o),
  .last_i       (last_o)
);

`default_nettype wire
